FILE: design/clm_pkg.sv
package clm_pkg;

  localparam logic [7:0] CH_NEWLINE   = 8'h0a;
  localparam logic [7:0] CH_STAR      = 8'h2a;
  localparam logic [7:0] CH_SLASH     = 8'h2f;
  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_TICK      = 8'h60;
  localparam logic [7:0] CH_SPACE     = 8'h20;

endpackage

FILE: design/comment_literal_masker_unit.sv
// path: an accepted input word is registered, then its result words in the result buffer
// throughput: 1 word per cycle while out_tready is high and each word yields at most
//   one output word; an input word that yields two output words holds the input side
//   until the two-entry result buffer, draining one word per cycle, holds one word
// reset: rst_n synchronous active low, clears buffers and returns the lexer to plain text
module comment_literal_masker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_in[7:0]
  input  logic       in_tlast,   // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // char_out[7:0]
  output logic       out_tlast   // end_of_text
);

  typedef enum logic [2:0] {
    MODE_PLAIN  = 3'd0,
    MODE_LINE   = 3'd1,
    MODE_BLOCK  = 3'd2,
    MODE_SINGLE = 3'd3,
    MODE_DOUBLE = 3'd4,
    MODE_TICK   = 3'd5
  } lex_mode_t;

  logic       in_valid_r;
  logic [7:0] in_char_r;
  logic       in_last_r;

  lex_mode_t  mode_r, mode_nxt;
  logic       esc_r, esc_nxt;
  logic       star_r, star_nxt;
  logic       held_r, held_nxt;

  logic [1:0] cnt_r, cnt_nxt;
  logic [7:0] slot0_char_r, slot0_char_nxt;
  logic       slot0_last_r, slot0_last_nxt;
  logic [7:0] slot1_char_r, slot1_char_nxt;
  logic       slot1_last_r, slot1_last_nxt;

  logic       proc_go;
  logic       pop;
  logic [1:0] res_n;
  logic [7:0] res0_char;
  logic [7:0] res1_char;

  logic       pb_emit;
  logic [7:0] pb_char;
  lex_mode_t  pb_mode;
  logic       pb_held;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = slot0_char_r;
  assign out_tlast  = slot0_last_r;
  assign pop        = out_tvalid && out_tready;
  assign proc_go    = in_valid_r && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready));
  assign in_tready  = !in_valid_r || proc_go;

  // plain text byte, held slash already resolved
  always_comb begin
    pb_emit = 1'b1;
    pb_char = in_char_r;
    pb_mode = MODE_PLAIN;
    pb_held = 1'b0;
    if ((in_char_r == clm_pkg::CH_SLASH) && !in_last_r) begin
      pb_emit = 1'b0;
      pb_held = 1'b1;
    end else if (in_char_r == clm_pkg::CH_SQUOTE) begin
      pb_char = clm_pkg::CH_SPACE;
      pb_mode = MODE_SINGLE;
    end else if (in_char_r == clm_pkg::CH_DQUOTE) begin
      pb_char = clm_pkg::CH_SPACE;
      pb_mode = MODE_DOUBLE;
    end else if (in_char_r == clm_pkg::CH_TICK) begin
      pb_char = clm_pkg::CH_SPACE;
      pb_mode = MODE_TICK;
    end
  end

  always_comb begin
    res_n     = 2'd1;
    res0_char = clm_pkg::CH_SPACE;
    res1_char = clm_pkg::CH_SPACE;
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    star_nxt  = star_r;
    held_nxt  = held_r;
    case (mode_r)
      MODE_LINE: begin
        if (in_char_r == clm_pkg::CH_NEWLINE) begin
          res0_char = in_char_r;
          mode_nxt  = MODE_PLAIN;
        end
      end
      MODE_BLOCK: begin
        if (star_r && (in_char_r == clm_pkg::CH_SLASH)) begin
          mode_nxt = MODE_PLAIN;
          star_nxt = 1'b0;
        end else begin
          star_nxt = (in_char_r == clm_pkg::CH_STAR);
        end
      end
      MODE_SINGLE, MODE_DOUBLE, MODE_TICK: begin
        if (esc_r) begin
          esc_nxt = 1'b0;
        end else if (in_char_r == clm_pkg::CH_BACKSLASH) begin
          esc_nxt = 1'b1;
        end else if (((mode_r == MODE_SINGLE) && (in_char_r == clm_pkg::CH_SQUOTE)) ||
                     ((mode_r == MODE_DOUBLE) && (in_char_r == clm_pkg::CH_DQUOTE)) ||
                     ((mode_r == MODE_TICK) && (in_char_r == clm_pkg::CH_TICK))) begin
          mode_nxt = MODE_PLAIN;
        end
      end
      default: begin
        if (held_r) begin
          held_nxt = 1'b0;
          if (in_char_r == clm_pkg::CH_SLASH) begin
            res_n    = 2'd2;
            mode_nxt = MODE_LINE;
          end else if (in_char_r == clm_pkg::CH_STAR) begin
            res_n    = 2'd2;
            mode_nxt = MODE_BLOCK;
            star_nxt = 1'b0;
          end else begin
            res_n     = pb_emit ? 2'd2 : 2'd1;
            res0_char = clm_pkg::CH_SLASH;
            res1_char = pb_char;
            mode_nxt  = pb_mode;
            held_nxt  = pb_held;
          end
        end else begin
          res_n     = pb_emit ? 2'd1 : 2'd0;
          res0_char = pb_char;
          mode_nxt  = pb_mode;
          held_nxt  = pb_held;
        end
      end
    endcase
    if (in_last_r) begin
      mode_nxt = MODE_PLAIN;
      esc_nxt  = 1'b0;
      star_nxt = 1'b0;
      held_nxt = 1'b0;
    end
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    slot0_char_nxt = slot0_char_r;
    slot0_last_nxt = slot0_last_r;
    slot1_char_nxt = slot1_char_r;
    slot1_last_nxt = slot1_last_r;
    if (proc_go) begin
      cnt_nxt        = res_n;
      slot0_char_nxt = res0_char;
      slot0_last_nxt = in_last_r && (res_n == 2'd1);
      slot1_char_nxt = res1_char;
      slot1_last_nxt = in_last_r;
    end else if (pop) begin
      cnt_nxt        = cnt_r - 2'd1;
      slot0_char_nxt = slot1_char_r;
      slot0_last_nxt = slot1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      cnt_r      <= 2'd0;
      mode_r     <= MODE_PLAIN;
      esc_r      <= 1'b0;
      star_r     <= 1'b0;
      held_r     <= 1'b0;
    end else begin
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      cnt_r <= cnt_nxt;
      if (proc_go) begin
        mode_r <= mode_nxt;
        esc_r  <= esc_nxt;
        star_r <= star_nxt;
        held_r <= held_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
    slot0_char_r <= slot0_char_nxt;
    slot0_last_r <= slot0_last_nxt;
    slot1_char_r <= slot1_char_nxt;
    slot1_last_r <= slot1_last_nxt;
  end

`ifndef NO_ASSERTIONS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("result buffer count out of range");

  a_slot_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && out_tready) |=> (out_tdata == $past(slot1_char_r) && out_tvalid))
    else $error("second result word lost on drain");

  a_held_plain: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (mode_r == MODE_PLAIN))
    else $error("slash held outside plain text");

  a_star_block: assert property (@(posedge clk) disable iff (!rst_n)
    star_r |-> (mode_r == MODE_BLOCK))
    else $error("star flag outside block comment");

  a_esc_literal: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r |-> (mode_r == MODE_SINGLE || mode_r == MODE_DOUBLE || mode_r == MODE_TICK))
    else $error("escape pending outside literal");
`endif

endmodule

FILE: test/tb_comment_literal_masker_unit.sv
`timescale 1ns / 100ps

module tb_comment_literal_masker_unit;

  localparam int RANDOM_WORDS = 1500;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 300;

  typedef enum logic [2:0] {
    LX_PLAIN, LX_LINE, LX_BLOCK, LX_SQ, LX_DQ, LX_TICK
  } lx_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eot;
  } out_word_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
    logic       typed;
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
  } word_row_t;

  localparam out_word_t SP_W = '{clm_pkg::CH_SPACE, 1'b0};
  localparam out_word_t NO_W = '{8'h00, 1'b0};

  // typed rows carry their expected words, the rest go through the predictor
  localparam word_row_t DIR_TAB [27] = '{
    '{8'h61,                 1'b0, 1'b1, 2'd1, '{8'h61, 1'b0}, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b1, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b1, 2'd2, SP_W, SP_W},
    '{8'h78,                 1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_NEWLINE,   1'b0, 1'b1, 2'd1, '{clm_pkg::CH_NEWLINE, 1'b0}, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_STAR,      1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{8'h71,                 1'b0, 1'b1, 2'd2, '{clm_pkg::CH_SLASH, 1'b0}, '{8'h71, 1'b0}},
    '{clm_pkg::CH_DQUOTE,    1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_BACKSLASH, 1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_DQUOTE,    1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_NEWLINE,   1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_DQUOTE,    1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SQUOTE,    1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{8'hff,                 1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SQUOTE,    1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_TICK,      1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{8'h00,                 1'b1, 1'b1, 2'd1, '{clm_pkg::CH_SPACE, 1'b1}, NO_W},
    '{clm_pkg::CH_SLASH,     1'b1, 1'b1, 2'd1, '{clm_pkg::CH_SLASH, 1'b1}, NO_W},
    '{clm_pkg::CH_SLASH,     1'b0, 1'b0, 2'd0, NO_W, NO_W},
    '{clm_pkg::CH_SQUOTE,    1'b1, 1'b1, 2'd2,
      '{clm_pkg::CH_SLASH, 1'b0}, '{clm_pkg::CH_SPACE, 1'b1}},
    '{8'hff,                 1'b1, 1'b1, 2'd1, '{8'hff, 1'b1}, NO_W}
  };

  logic       clk;
  logic       rst_n;
  logic       in_tvalid;
  logic       in_tready;
  logic [7:0] in_tdata;   // char_in[7:0]
  logic       in_tlast;   // is_final
  logic       out_tvalid;
  logic       out_tready;
  logic [7:0] out_tdata;  // char_out[7:0]
  logic       out_tlast;  // end_of_text

  lx_mode_t lx_mode;
  logic     lx_escape;
  logic     lx_star;
  logic     lx_held;

  out_word_t masked_q [$];
  word_row_t row_q [$];
  int        words_in;
  int        words_out;
  int        texts_sent;
  int        errors;
  int        cycles;
  bit        pressure_done;

  comment_literal_masker_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit calm_window();
    return words_in >= 700 && words_in < 1000;
  endfunction

  function automatic void mask_byte(input logic [7:0] c, input logic fin,
                                    output logic [1:0] n, output out_word_t w0,
                                    output out_word_t w1);
    logic [7:0] r [2];
    int         cnt;
    bit         as_plain;
    bit         is_quote;
    cnt = 0;
    as_plain = 1'b0;
    r[0] = 8'h00;
    r[1] = 8'h00;
    is_quote = (c == clm_pkg::CH_SQUOTE) || (c == clm_pkg::CH_DQUOTE) ||
               (c == clm_pkg::CH_TICK);
    if (lx_mode == LX_LINE) begin
      r[0] = (c == clm_pkg::CH_NEWLINE) ? c : clm_pkg::CH_SPACE;
      cnt = 1;
      if (c == clm_pkg::CH_NEWLINE) lx_mode = LX_PLAIN;
    end else if (lx_mode == LX_BLOCK) begin
      r[0] = clm_pkg::CH_SPACE;
      cnt = 1;
      if (lx_star && c == clm_pkg::CH_SLASH) begin
        lx_mode = LX_PLAIN;
        lx_star = 1'b0;
      end else begin
        lx_star = (c == clm_pkg::CH_STAR);
      end
    end else if (lx_mode == LX_SQ || lx_mode == LX_DQ || lx_mode == LX_TICK) begin
      r[0] = clm_pkg::CH_SPACE;
      cnt = 1;
      if (lx_escape) begin
        lx_escape = 1'b0;
      end else if (c == clm_pkg::CH_BACKSLASH) begin
        lx_escape = 1'b1;
      end else if ((lx_mode == LX_SQ && c == clm_pkg::CH_SQUOTE) ||
                   (lx_mode == LX_DQ && c == clm_pkg::CH_DQUOTE) ||
                   (lx_mode == LX_TICK && c == clm_pkg::CH_TICK)) begin
        lx_mode = LX_PLAIN;
      end
    end else if (lx_held) begin
      lx_held = 1'b0;
      if (c == clm_pkg::CH_SLASH || c == clm_pkg::CH_STAR) begin
        r[0] = clm_pkg::CH_SPACE;
        r[1] = clm_pkg::CH_SPACE;
        cnt = 2;
        lx_mode = (c == clm_pkg::CH_SLASH) ? LX_LINE : LX_BLOCK;
        lx_star = 1'b0;
      end else begin
        r[0] = clm_pkg::CH_SLASH;
        cnt = 1;
        as_plain = 1'b1;
      end
    end else begin
      as_plain = 1'b1;
    end
    if (as_plain) begin
      if (c == clm_pkg::CH_SLASH && !fin) begin
        lx_held = 1'b1;
      end else begin
        case (c)
          clm_pkg::CH_SQUOTE: lx_mode = LX_SQ;
          clm_pkg::CH_DQUOTE: lx_mode = LX_DQ;
          clm_pkg::CH_TICK:   lx_mode = LX_TICK;
          default:            ;
        endcase
        r[cnt] = is_quote ? clm_pkg::CH_SPACE : c;
        cnt++;
      end
    end
    if (fin) begin
      lx_mode = LX_PLAIN;
      lx_escape = 1'b0;
      lx_star = 1'b0;
      lx_held = 1'b0;
    end
    n = 2'(cnt);
    w0 = '{r[0], fin && cnt == 1};
    w1 = '{r[1], fin && cnt == 2};
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(11))
      0:       return clm_pkg::CH_SLASH;
      1:       return clm_pkg::CH_STAR;
      2:       return clm_pkg::CH_BACKSLASH;
      3:       return clm_pkg::CH_SQUOTE;
      4:       return clm_pkg::CH_DQUOTE;
      5:       return clm_pkg::CH_TICK;
      6:       return clm_pkg::CH_NEWLINE;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic send_word(input word_row_t row);
    while (!calm_window() && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    row_q = {row_q, row};
    in_tvalid <= 1'b1;
    in_tdata  <= row.ch;
    in_tlast  <= row.fin;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_text();
    logic [7:0] txt [$];
    logic [7:0] q;
    word_row_t  row;
    int         chunks;
    int         len;
    chunks = ($urandom_range(19) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
    for (int k = 0; k < chunks; k++) begin
      len = $urandom_range(10);
      case ($urandom_range(9))
        0: begin
          txt = {txt, clm_pkg::CH_SLASH, clm_pkg::CH_SLASH};
          repeat (len) txt = {txt, pick_byte()};
          if ($urandom_range(4) != 0) txt = {txt, clm_pkg::CH_NEWLINE};
        end
        1: begin
          txt = {txt, clm_pkg::CH_SLASH, clm_pkg::CH_STAR};
          repeat (len) txt = {txt, pick_byte()};
          if ($urandom_range(4) != 0) begin
            txt = {txt, clm_pkg::CH_STAR, clm_pkg::CH_SLASH};
          end
        end
        2, 3, 4: begin
          q = ($urandom_range(2) == 0) ? clm_pkg::CH_SQUOTE :
              ($urandom_range(1) == 0) ? clm_pkg::CH_DQUOTE : clm_pkg::CH_TICK;
          txt = {txt, q};
          repeat (len) txt = {txt, pick_byte()};
          if ($urandom_range(4) != 0) txt = {txt, q};
        end
        5: begin
          txt = {txt, clm_pkg::CH_SLASH};
          txt = {txt, pick_byte()};
        end
        default: begin
          repeat (len / 2 + 1) txt = {txt, pick_byte()};
        end
      endcase
    end
    foreach (txt[i]) begin
      row = '0;
      row.ch = txt[i];
      row.fin = (i == txt.size() - 1);
      send_word(row);
    end
    texts_sent++;
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= 8'h00;
    in_tlast   <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (DIR_TAB[i]) send_word(DIR_TAB[i]);
    while (words_in < RANDOM_WORDS + $size(DIR_TAB)) send_text();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (masked_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("tb: %0d words in (%0d random texts), %0d words out", words_in, texts_sent,
             words_out);
    $display("tb: line/block comments, quoted literals with escapes, held slashes, stalls");
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: %0d mismatches", errors);
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls plus one long hold-off to back up the input side
  initial begin
    out_tready <= 1'b0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (!pressure_done && words_in >= 400) begin
        pressure_done = 1'b1;
        out_tready <= 1'b0;
        for (int h = 0; h < HOLD_CYCLES; h++) @(posedge clk);
      end else begin
        out_tready <= calm_window() || $urandom_range(99) >= 17;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    logic [1:0] n;
    out_word_t  w0;
    out_word_t  w1;
    out_word_t  want;
    word_row_t  row;
    if (rst_n && in_tvalid && in_tready) begin
      mask_byte(in_tdata, in_tlast, n, w0, w1);
      row = row_q.pop_front();
      if (row.typed) begin
        n = row.n;
        w0 = row.w0;
        w1 = row.w1;
      end
      if (n > 0) masked_q = {masked_q, w0};
      if (n > 1) masked_q = {masked_q, w1};
      words_in++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      words_out++;
      if (masked_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("tb: unexpected word %h last %b", out_tdata, out_tlast);
      end else begin
        want = masked_q.pop_front();
        if (want.ch !== out_tdata || want.eot !== out_tlast) begin
          errors++;
          if (errors <= 10)
            $display("tb: word %0d expected %h last %b, got %h last %b", words_out,
                     want.ch, want.eot, out_tdata, out_tlast);
        end
      end
    end
  end

  initial begin
    lx_mode       = LX_PLAIN;
    lx_escape     = 1'b0;
    lx_star       = 1'b0;
    lx_held       = 1'b0;
    words_in      = 0;
    words_out     = 0;
    texts_sent    = 0;
    errors        = 0;
    cycles        = 0;
    pressure_done = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout with %0d words pending", masked_q.size());
      $display("tb: failure");
      $finish;
    end
  end

endmodule
